@@ hw/rtl/kps_pkg.sv @@
package kps_pkg;

    localparam int MAX_LINES  = 16;
    localparam int MAX_PEOPLE = 8;
    localparam int MAX_JOINTS = 32;
    localparam int Q_DEPTH    = 2;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_CONF_THR  = 2'd1;
    localparam logic [1:0] CFG_DIST_THR  = 2'd2;
    localparam logic [1:0] CFG_LINES     = 2'd3;

    localparam logic        RST_ENABLE   = 1'b0;
    localparam logic [7:0]  RST_CONF_THR = 8'd128;
    localparam logic [15:0] RST_DIST_THR = 16'd160;
    localparam logic [4:0]  RST_LINES    = 5'd0;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_START,
        SEL_END,
        SEL_PERP
    } t_sel;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
    } t_seg;

    typedef struct packed {
        t_op         op;
        logic [3:0]  slot;
        t_seg        seg;
        logic [2:0]  person;
        logic [4:0]  joint;
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  conf;
    } t_req;

    typedef struct packed {
        logic        enable;
        logic [7:0]  conf_thr;
        logic [15:0] dist_thr;
        logic [4:0]  lines;
    } t_cfg;

endpackage

@@ hw/rtl/keypoint_segment_proximity.sv @@
// Tests keypoints against a table of up to MAX_LINES line segments. A request with
// opcode 0 loads a segment into a slot; opcode 1 tests a keypoint and yields one
// result per nonzero-length segment nearer than distance_threshold, in ascending
// slot order, the final one flagged by o_last. A load is written to the table; a
// keypoint that is skipped is dropped at the front and never reaches the back end.
// A tested keypoint holds the back end until its lines_in_use (saturated at
// MAX_LINES) segments have passed and the pipeline is empty: the single table read
// port feeds one segment per cycle through a registered read into a four-stage
// distance pipeline; both halt while a result waits to be taken. A two-entry queue
// parts the request port from this work so further requests are taken meanwhile.
module keypoint_segment_proximity #(
    parameter int MAX_LINES = kps_pkg::MAX_LINES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [3:0]  i_line_slot,
    input  logic [15:0] i_seg_start_x,
    input  logic [15:0] i_seg_start_y,
    input  logic [15:0] i_seg_end_x,
    input  logic [15:0] i_seg_end_y,
    input  logic [2:0]  i_person_id,
    input  logic [4:0]  i_joint_id,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic [7:0]  i_point_confidence,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_hit_line,
    output logic [2:0]  o_hit_person,
    output logic [4:0]  o_hit_joint,
    output logic [15:0] o_hit_x,
    output logic [15:0] o_hit_y,
    output logic [7:0]  o_hit_confidence,
    output logic [31:0] o_events_total,
    output logic        o_last
);

    kps_pkg::t_req in_req, f_req, q_req;
    kps_pkg::t_cfg cfg;
    logic          f_push, q_ready, q_valid, q_pop;

    always_comb begin
        in_req.op     = kps_pkg::t_op'(i_opcode);
        in_req.slot   = i_line_slot;
        in_req.seg.sx = i_seg_start_x;
        in_req.seg.sy = i_seg_start_y;
        in_req.seg.ex = i_seg_end_x;
        in_req.seg.ey = i_seg_end_y;
        in_req.person = i_person_id;
        in_req.joint  = i_joint_id;
        in_req.px     = i_point_x;
        in_req.py     = i_point_y;
        in_req.conf   = i_point_confidence;
    end

    kps_front #(
        .MAX_LINES(MAX_LINES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_req      (in_req),
        .i_q_ready  (q_ready),
        .o_push     (f_push),
        .o_req      (f_req),
        .o_cfg      (cfg)
    );

    kps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_req   (f_req),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    kps_back #(
        .MAX_LINES(MAX_LINES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_valid        (q_valid),
        .i_q_req          (q_req),
        .o_q_pop          (q_pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_hit_line       (o_hit_line),
        .o_hit_person     (o_hit_person),
        .o_hit_joint      (o_hit_joint),
        .o_hit_x          (o_hit_x),
        .o_hit_y          (o_hit_y),
        .o_hit_confidence (o_hit_confidence),
        .o_events_total   (o_events_total),
        .o_last           (o_last)
    );

endmodule

@@ hw/rtl/kps_front.sv @@
module kps_front #(
    parameter int MAX_LINES = kps_pkg::MAX_LINES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  kps_pkg::t_req i_req,
    input  logic          i_q_ready,
    output logic          o_push,
    output kps_pkg::t_req o_req,
    output kps_pkg::t_cfg o_cfg
);

    kps_pkg::t_cfg r_cfg;
    logic          keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= kps_pkg::RST_ENABLE;
            r_cfg.conf_thr <= kps_pkg::RST_CONF_THR;
            r_cfg.dist_thr <= kps_pkg::RST_DIST_THR;
            r_cfg.lines    <= kps_pkg::RST_LINES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kps_pkg::CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                kps_pkg::CFG_CONF_THR: r_cfg.conf_thr <= i_cfg_data[7:0];
                kps_pkg::CFG_DIST_THR: r_cfg.dist_thr <= i_cfg_data;
                kps_pkg::CFG_LINES:    r_cfg.lines    <= i_cfg_data[4:0];
            endcase
        end
    end

    // drop loads beyond the table and keypoints that cannot hit
    always_comb begin
        if (i_req.op == kps_pkg::OP_LOAD) begin
            keep = 32'(i_req.slot) < 32'(MAX_LINES);
        end else begin
            keep = r_cfg.enable
                && (32'(i_req.person) < 32'(kps_pkg::MAX_PEOPLE))
                && (32'(i_req.joint) < 32'(kps_pkg::MAX_JOINTS))
                && (i_req.conf >= r_cfg.conf_thr);
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;
    assign o_req   = i_req;
    assign o_cfg   = r_cfg;

endmodule

@@ hw/rtl/kps_queue.sv @@
module kps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kps_pkg::t_req i_req,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output kps_pkg::t_req o_req
);

    localparam int PW = (kps_pkg::Q_DEPTH > 1) ? $clog2(kps_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(kps_pkg::Q_DEPTH + 1);

    kps_pkg::t_req r_mem [kps_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_ready = r_cnt < CW'(kps_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(kps_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(kps_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

@@ hw/rtl/kps_dist.sv @@
module kps_dist #(
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [IW-1:0] i_idx,
    input  kps_pkg::t_seg i_seg,
    input  logic [15:0]   i_px,
    input  logic [15:0]   i_py,
    input  logic [31:0]   i_t2,
    output logic          o_valid,
    output logic [IW-1:0] o_idx,
    output logic          o_hit,
    output logic          o_busy
);

    logic r_v2, r_v3, r_v4, r_v5;
    logic [IW-1:0] r_i2, r_i3, r_i4, r_i5;

    logic signed [16:0] r_a, r_b, r_c, r_d, r_ax, r_ay;
    logic signed [33:0] r_aa, r_bb, r_cc, r_dd, r_ac, r_bd, r_ad, r_bc, r_xx, r_yy;
    logic signed [34:0] r_len, r_dot, r_cross, r_ds, r_de;
    logic [67:0]        r_lhs;
    logic [65:0]        r_rhs;
    kps_pkg::t_sel      r_sel;
    logic               r_ds_hit, r_de_hit;

    logic [33:0]        n_cr;
    logic [33:0]        n_len;
    kps_pkg::t_sel      n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_cr  = r_cross[34] ? 34'(-r_cross) : 34'(r_cross);
        n_len = r_len[33:0];
        if (n_len == '0) begin
            n_sel = kps_pkg::SEL_NONE;
        end else if (r_dot <= 35'sd0) begin
            n_sel = kps_pkg::SEL_START;
        end else if (r_dot >= r_len) begin
            n_sel = kps_pkg::SEL_END;
        end else begin
            n_sel = kps_pkg::SEL_PERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_i2 <= i_idx;
            r_i3 <= r_i2;
            r_i4 <= r_i3;
            r_i5 <= r_i4;

            r_a  <= $signed({1'b0, i_px}) - $signed({1'b0, i_seg.sx});
            r_b  <= $signed({1'b0, i_py}) - $signed({1'b0, i_seg.sy});
            r_c  <= $signed({1'b0, i_seg.ex}) - $signed({1'b0, i_seg.sx});
            r_d  <= $signed({1'b0, i_seg.ey}) - $signed({1'b0, i_seg.sy});
            r_ax <= $signed({1'b0, i_px}) - $signed({1'b0, i_seg.ex});
            r_ay <= $signed({1'b0, i_py}) - $signed({1'b0, i_seg.ey});

            r_aa <= r_a * r_a;
            r_bb <= r_b * r_b;
            r_cc <= r_c * r_c;
            r_dd <= r_d * r_d;
            r_ac <= r_a * r_c;
            r_bd <= r_b * r_d;
            r_ad <= r_a * r_d;
            r_bc <= r_b * r_c;
            r_xx <= r_ax * r_ax;
            r_yy <= r_ay * r_ay;

            r_len   <= 35'(r_cc) + 35'(r_dd);
            r_dot   <= 35'(r_ac) + 35'(r_bd);
            r_cross <= 35'(r_ad) - 35'(r_bc);
            r_ds    <= 35'(r_aa) + 35'(r_bb);
            r_de    <= 35'(r_xx) + 35'(r_yy);

            r_lhs    <= 68'(n_cr) * 68'(n_cr);
            r_rhs    <= 66'(i_t2) * 66'(n_len);
            r_sel    <= n_sel;
            r_ds_hit <= r_ds[33:0] < 34'(i_t2);
            r_de_hit <= r_de[33:0] < 34'(i_t2);
        end
    end

    always_comb begin
        unique case (r_sel)
            kps_pkg::SEL_NONE:  o_hit = 1'b0;
            kps_pkg::SEL_START: o_hit = r_ds_hit;
            kps_pkg::SEL_END:   o_hit = r_de_hit;
            kps_pkg::SEL_PERP:  o_hit = r_lhs < 68'(r_rhs);
        endcase
    end

    assign o_valid = r_v5;
    assign o_idx   = r_i5;
    assign o_busy  = r_v2 || r_v3 || r_v4 || r_v5;

endmodule

@@ hw/rtl/kps_back.sv @@
module kps_back #(
    parameter int MAX_LINES = kps_pkg::MAX_LINES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kps_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  kps_pkg::t_req i_q_req,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [3:0]    o_hit_line,
    output logic [2:0]    o_hit_person,
    output logic [4:0]    o_hit_joint,
    output logic [15:0]   o_hit_x,
    output logic [15:0]   o_hit_y,
    output logic [7:0]    o_hit_confidence,
    output logic [31:0]   o_events_total,
    output logic          o_last
);

    localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);

    kps_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   n_lines;
    logic [2:0]      r_person;
    logic [4:0]      r_joint;
    logic [15:0]     r_px, r_py;
    logic [7:0]      r_conf;
    logic [31:0]     r_t2;

    kps_pkg::t_seg   r_mem [MAX_LINES];
    kps_pkg::t_seg   r_rd;
    logic            r_v1;
    logic [IW-1:0]   r_i1;

    logic            r_pend_v;
    logic [IW-1:0]   r_pend_i;
    logic [31:0]     r_evt;
    logic            r_out_valid;

    logic            adv, issue, pop, busy, take, emit, flush;
    logic            d_valid, d_hit, d_busy;
    logic [IW-1:0]   d_idx;

    assign adv = !r_out_valid || i_ready;

    always_comb begin
        if (32'(i_cfg.lines) > 32'(MAX_LINES)) begin
            n_lines = CW'(MAX_LINES);
        end else begin
            n_lines = CW'(i_cfg.lines);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        pop     = 1'b0;
        issue   = 1'b0;
        flush   = 1'b0;
        unique case (r_state)
            kps_pkg::S_IDLE: begin
                pop = i_q_valid;
                if (i_q_valid && i_q_req.op == kps_pkg::OP_POINT) begin
                    n_state = (n_lines == '0) ? kps_pkg::S_DRAIN : kps_pkg::S_RUN;
                end
            end
            kps_pkg::S_RUN: begin
                issue = adv;
                if (adv && r_cnt == r_n - 1'b1) begin
                    n_state = kps_pkg::S_DRAIN;
                end
            end
            kps_pkg::S_DRAIN: begin
                if (!busy) begin
                    if (!r_pend_v) begin
                        n_state = kps_pkg::S_IDLE;
                    end else if (adv) begin
                        flush   = 1'b1;
                        n_state = kps_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = kps_pkg::S_IDLE;
        endcase
    end

    assign o_q_pop = pop;
    assign busy    = r_v1 || d_busy;
    assign take    = adv && d_valid && d_hit;
    assign emit    = (take && r_pend_v) || flush;

    always_ff @(posedge i_clk) begin
        if (pop && i_q_req.op == kps_pkg::OP_LOAD) begin
            r_mem[IW'(i_q_req.slot)] <= i_q_req.seg;
        end
        if (issue) begin
            r_rd <= r_mem[r_cnt[IW-1:0]];
            r_i1 <= r_cnt[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_req.op == kps_pkg::OP_POINT) begin
            r_person <= i_q_req.person;
            r_joint  <= i_q_req.joint;
            r_px     <= i_q_req.px;
            r_py     <= i_q_req.py;
            r_conf   <= i_q_req.conf;
            r_t2     <= 32'(i_cfg.dist_thr) * 32'(i_cfg.dist_thr);
            r_n      <= n_lines;
        end
        if (take) begin
            r_pend_i <= d_idx;
        end
        if (emit) begin
            o_hit_line       <= 4'(r_pend_i);
            o_hit_person     <= r_person;
            o_hit_joint      <= r_joint;
            o_hit_x          <= r_px;
            o_hit_y          <= r_py;
            o_hit_confidence <= r_conf;
            o_events_total   <= r_evt + 32'd1;
            o_last           <= flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_pend_v    <= 1'b0;
            r_evt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (adv) begin
                r_v1 <= issue;
            end
            if (take) begin
                r_pend_v <= 1'b1;
            end else if (flush) begin
                r_pend_v <= 1'b0;
            end
            if (emit) begin
                r_evt       <= r_evt + 32'd1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    kps_dist #(
        .IW(IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_v1),
        .i_idx   (r_i1),
        .i_seg   (r_rd),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_t2    (r_t2),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_hit   (d_hit),
        .o_busy  (d_busy)
    );

    assign o_valid = r_out_valid;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kps_pkg::S_IDLE) |-> (!busy && !r_pend_v))
        else $error("work left in flight while idle");

    a_evt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_evt == $past(r_evt) + 32'd1))
        else $error("event count did not advance on emit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kps_pkg::S_RUN && r_out_valid && !i_ready) |=> $stable(r_cnt))
        else $error("segment issue advanced under output stall");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_ready))
        else $error("result overwritten before taken");

endmodule
